[design/indexed_min_priority_queue_assert.svh]
// ----------------------------------------------------------------------------
// Assertion macros for the indexed min priority queue
// Shared forms for concurrent checks clocked on aclk, disabled in reset.
// ----------------------------------------------------------------------------
`ifndef INDEXED_MIN_PRIORITY_QUEUE_ASSERT_SVH
`define INDEXED_MIN_PRIORITY_QUEUE_ASSERT_SVH

// Same-cycle implication
`define IMPQ_ASSERT_SAME(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("queue check failed");

// Next-cycle implication
`define IMPQ_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("queue check failed");

`endif

[design/iminpq_pkg.sv]
// ----------------------------------------------------------------------------
// Indexed min priority queue package
// Operation codes and fixed field widths of the queue channels.
// ----------------------------------------------------------------------------
package iminpq_pkg;

    localparam int VERTEX_BITS    = 10;
    localparam int VERTEX_COUNT   = 1 << VERTEX_BITS;
    localparam int OP_BITS        = 2;
    localparam int REQ_PRIO_BITS  = 32;
    localparam int OUT_PRIO_BITS  = 32;
    localparam int COUNT_OUT_BITS = 11;
    localparam int S_DATA_BITS    = 48;
    localparam int M_DATA_BITS    = 56;

    typedef enum logic [OP_BITS-1:0] {
        OP_PUSH   = 2'd0,
        OP_POP    = 2'd1,
        OP_LOOKUP = 2'd2
    } op_t;

endpackage

[design/iminpq_ram.sv]
// ----------------------------------------------------------------------------
// Generic simple dual-port RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module iminpq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write and registered read
    always_ff @(posedge clk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

[design/indexed_min_priority_queue.sv]
// ----------------------------------------------------------------------------
// Indexed min priority queue
// Binary min-heap of vertex ids with a vertex-to-slot position map.
// ----------------------------------------------------------------------------
// Usage:
//   Input stream: s_tuser carries the operation (push or decrease key, extract
//   minimum, lookup), s_tdata the vertex and the requested priority.
//   Result stream: one transaction per input transaction, in order.
//   Heap entries live in one RAM (slots 1..count), the position map in a
//   second RAM indexed by vertex; each has registered read data.
//   A lookup reads the position map, then the heap slot it names. A push
//   climbs the heap, reading the parent and writing one slot per level; an
//   extract descends it, reading both children and writing one slot per
//   level.
//   One item is worked at a time; the next item is accepted while a finished
//   result still sits in the output register.
//   Reset: a clearing pass writes the 1024 position map entries, one per
//   cycle, so s_tready stays low after reset releases until the pass ends.
//   Receiver stall: the result holds in the output register; a second result
//   waits in the core until the register drains.
// ----------------------------------------------------------------------------
module indexed_min_priority_queue
    import iminpq_pkg::*;
#(
    parameter int CAPACITY  = 1024,
    parameter int PRIO_BITS = 32
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_tvalid,
    output logic                   s_tready,
    input  logic [S_DATA_BITS-1:0] s_tdata,  // vertex[9:0], priority_req[41:10], zero fill
    input  logic [OP_BITS-1:0]     s_tuser,  // operation[1:0]
    output logic                   m_tvalid,
    input  logic                   m_tready,
    output logic [M_DATA_BITS-1:0] m_tdata   // out_vertex[9:0], out_priority[41:10],
                                             // found[42], is_empty[43],
                                             // entry_count[54:44], error[55]
);

    localparam int SW = $clog2(CAPACITY + 1);
    localparam int HW = VERTEX_BITS + PRIO_BITS;

    typedef enum logic [3:0] {
        ST_CLEAR, ST_IDLE, ST_PUSH_POS, ST_PUSH_CMP, ST_UP_RD, ST_UP_CMP,
        ST_POP_TOP, ST_POP_LAST, ST_DN_LEFT, ST_DN_RIGHT, ST_DN_CMP,
        ST_LOOK_POS, ST_LOOK_CHK, ST_DONE
    } state_t;

    state_t                 state_reg, state_next;
    logic [VERTEX_BITS-1:0] vtx_reg, vtx_next;
    logic [PRIO_BITS-1:0]   prio_reg, prio_next;
    logic [SW-1:0]          slot_reg, slot_next;
    logic [SW-1:0]          count_reg, count_next;
    logic [HW-1:0]          lchild_reg, lchild_next;
    logic                   has_right_reg, has_right_next;
    logic [VERTEX_BITS-1:0] clr_reg, clr_next;
    logic [VERTEX_BITS-1:0] res_vertex_reg, res_vertex_next;
    logic [PRIO_BITS-1:0]   res_prio_reg, res_prio_next;
    logic                   res_found_reg, res_found_next;
    logic                   res_error_reg, res_error_next;
    logic                   m_tvalid_reg, m_tvalid_next;
    logic [M_DATA_BITS-1:0] m_tdata_reg, m_tdata_next;

    // RAM ports
    logic                   pm_we;
    logic [VERTEX_BITS-1:0] pm_waddr, pm_raddr;
    logic [SW-1:0]          pm_wdata, pm_rdata;
    logic                   hp_we;
    logic [SW-1:0]          hp_waddr, hp_raddr;
    logic [HW-1:0]          hp_wdata, hp_rdata;

    // Field views
    logic [VERTEX_BITS-1:0] in_vertex;
    logic [PRIO_BITS-1:0]   in_prio;
    logic [VERTEX_BITS-1:0] rd_vertex, ch_vertex;
    logic [PRIO_BITS-1:0]   rd_prio, lc_prio, ch_prio;
    logic [SW:0]            left_w, right_w;
    logic                   pos_valid, take_right;
    logic [SW-1:0]          parent_slot, child_slot;
    logic [HW-1:0]          child_data;

    assign in_vertex   = s_tdata[VERTEX_BITS-1:0];
    assign in_prio     = PRIO_BITS'(s_tdata[VERTEX_BITS +: REQ_PRIO_BITS]);
    assign rd_vertex   = hp_rdata[PRIO_BITS +: VERTEX_BITS];
    assign rd_prio     = hp_rdata[PRIO_BITS-1:0];
    assign lc_prio     = lchild_reg[PRIO_BITS-1:0];
    assign left_w      = {slot_reg, 1'b0};
    assign right_w     = left_w + (SW+1)'(1);
    assign pos_valid   = (pm_rdata != '0) && (pm_rdata <= count_reg);
    assign parent_slot = slot_reg >> 1;
    assign take_right  = has_right_reg && (rd_prio < lc_prio);
    assign child_data  = take_right ? hp_rdata : lchild_reg;
    assign child_slot  = take_right ? right_w[SW-1:0] : left_w[SW-1:0];
    assign ch_vertex   = child_data[PRIO_BITS +: VERTEX_BITS];
    assign ch_prio     = child_data[PRIO_BITS-1:0];

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    iminpq_ram #(.WIDTH(SW), .DEPTH(VERTEX_COUNT)) u_pos_ram (
        .clk   (aclk),
        .we    (pm_we),
        .waddr (pm_waddr),
        .wdata (pm_wdata),
        .raddr (pm_raddr),
        .rdata (pm_rdata)
    );

    iminpq_ram #(.WIDTH(HW), .DEPTH(CAPACITY + 1)) u_heap_ram (
        .clk   (aclk),
        .we    (hp_we),
        .waddr (hp_waddr),
        .wdata (hp_wdata),
        .raddr (hp_raddr),
        .rdata (hp_rdata)
    );

    // Sequence the heap operations
    always_comb begin
        state_next      = state_reg;
        vtx_next        = vtx_reg;
        prio_next       = prio_reg;
        slot_next       = slot_reg;
        count_next      = count_reg;
        lchild_next     = lchild_reg;
        has_right_next  = has_right_reg;
        clr_next        = clr_reg;
        res_vertex_next = res_vertex_reg;
        res_prio_next   = res_prio_reg;
        res_found_next  = res_found_reg;
        res_error_next  = res_error_reg;
        m_tvalid_next   = m_tvalid_reg && !m_tready;
        m_tdata_next    = m_tdata_reg;
        pm_we           = 1'b0;
        pm_waddr        = vtx_reg;
        pm_wdata        = slot_reg;
        pm_raddr        = in_vertex;
        hp_we           = 1'b0;
        hp_waddr        = slot_reg;
        hp_wdata        = {vtx_reg, prio_reg};
        hp_raddr        = '0;
        unique case (state_reg)
            ST_CLEAR: begin
                pm_we    = 1'b1;
                pm_waddr = clr_reg;
                pm_wdata = '0;
                clr_next = clr_reg + VERTEX_BITS'(1);
                if (clr_reg == '1) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (s_tvalid) begin
                    vtx_next        = in_vertex;
                    prio_next       = in_prio;
                    res_vertex_next = '0;
                    res_prio_next   = '0;
                    res_found_next  = 1'b0;
                    res_error_next  = 1'b0;
                    case (s_tuser)
                        OP_PUSH: state_next = ST_PUSH_POS;
                        OP_POP: begin
                            hp_raddr = SW'(1);
                            if (count_reg == '0) begin
                                res_error_next = 1'b1;
                                state_next     = ST_DONE;
                            end else begin
                                state_next = ST_POP_TOP;
                            end
                        end
                        OP_LOOKUP: begin
                            res_vertex_next = in_vertex;
                            state_next      = ST_LOOK_POS;
                        end
                        default: state_next = ST_DONE;
                    endcase
                end
            end
            ST_PUSH_POS: begin
                if (pos_valid) begin
                    slot_next  = pm_rdata;
                    hp_raddr   = pm_rdata;
                    state_next = ST_PUSH_CMP;
                end else if (count_reg < SW'(CAPACITY)) begin
                    count_next = count_reg + SW'(1);
                    slot_next  = count_reg + SW'(1);
                    state_next = ST_UP_RD;
                end else begin
                    state_next = ST_DONE;
                end
            end
            ST_PUSH_CMP: begin
                state_next = (prio_reg < rd_prio) ? ST_UP_RD : ST_DONE;
            end
            ST_UP_RD: begin
                if (slot_reg > SW'(1)) begin
                    hp_raddr   = parent_slot;
                    state_next = ST_UP_CMP;
                end else begin
                    hp_we      = 1'b1;
                    pm_we      = 1'b1;
                    state_next = ST_DONE;
                end
            end
            ST_UP_CMP: begin
                hp_we = 1'b1;
                pm_we = 1'b1;
                if (rd_prio < prio_reg) begin
                    state_next = ST_DONE;
                end else begin
                    // Pull the parent down one level
                    hp_wdata   = hp_rdata;
                    pm_waddr   = rd_vertex;
                    slot_next  = parent_slot;
                    state_next = ST_UP_RD;
                end
            end
            ST_POP_TOP: begin
                res_vertex_next = rd_vertex;
                res_prio_next   = rd_prio;
                pm_we           = 1'b1;
                pm_waddr        = rd_vertex;
                pm_wdata        = '0;
                hp_raddr        = count_reg;
                count_next      = count_reg - SW'(1);
                state_next      = ST_POP_LAST;
            end
            ST_POP_LAST: begin
                vtx_next  = rd_vertex;
                prio_next = rd_prio;
                slot_next = SW'(1);
                state_next = (count_reg == '0) ? ST_DONE : ST_DN_LEFT;
            end
            ST_DN_LEFT: begin
                if (left_w > (SW+1)'(count_reg)) begin
                    hp_we      = 1'b1;
                    pm_we      = 1'b1;
                    state_next = ST_DONE;
                end else begin
                    hp_raddr   = left_w[SW-1:0];
                    state_next = ST_DN_RIGHT;
                end
            end
            ST_DN_RIGHT: begin
                lchild_next    = hp_rdata;
                has_right_next = (right_w <= (SW+1)'(count_reg));
                hp_raddr       = right_w[SW-1:0];
                state_next     = ST_DN_CMP;
            end
            ST_DN_CMP: begin
                hp_we = 1'b1;
                pm_we = 1'b1;
                if (!(ch_prio < prio_reg)) begin
                    state_next = ST_DONE;
                end else begin
                    // Lift the smaller child one level
                    hp_wdata   = child_data;
                    pm_waddr   = ch_vertex;
                    slot_next  = child_slot;
                    state_next = ST_DN_LEFT;
                end
            end
            ST_LOOK_POS: begin
                if (pos_valid) begin
                    hp_raddr   = pm_rdata;
                    state_next = ST_LOOK_CHK;
                end else begin
                    state_next = ST_DONE;
                end
            end
            ST_LOOK_CHK: begin
                if (rd_vertex == vtx_reg) begin
                    res_found_next = 1'b1;
                    res_prio_next  = rd_prio;
                end
                state_next = ST_DONE;
            end
            ST_DONE: begin
                if (!m_tvalid_reg || m_tready) begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = {res_error_reg, COUNT_OUT_BITS'(count_reg),
                                     count_reg == '0, res_found_reg,
                                     OUT_PRIO_BITS'(res_prio_reg), res_vertex_reg};
                    state_next    = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // Hold state and registered outputs
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_CLEAR;
            count_reg    <= '0;
            clr_reg      <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            count_reg    <= count_next;
            clr_reg      <= clr_next;
            m_tvalid_reg <= m_tvalid_next;
        end
        vtx_reg        <= vtx_next;
        prio_reg       <= prio_next;
        slot_reg       <= slot_next;
        lchild_reg     <= lchild_next;
        has_right_reg  <= has_right_next;
        res_vertex_reg <= res_vertex_next;
        res_prio_reg   <= res_prio_next;
        res_found_reg  <= res_found_next;
        res_error_reg  <= res_error_next;
        m_tdata_reg    <= m_tdata_next;
    end

endmodule

[design/iminpq_checker.sv]
// ----------------------------------------------------------------------------
// Indexed min priority queue port checker
// Watches the result channel for stalls and field consistency.
// ----------------------------------------------------------------------------
`include "indexed_min_priority_queue_assert.svh"

module iminpq_checker
    import iminpq_pkg::*;
(
    input logic                   aclk,
    input logic                   aresetn,
    input logic                   m_tvalid,
    input logic                   m_tready,
    input logic [M_DATA_BITS-1:0] m_tdata
);

    // Stalled result holds
    `IMPQ_ASSERT_NEXT(a_stall_hold, aclk, aresetn, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata))

    // Empty flag agrees with count
    `IMPQ_ASSERT_SAME(a_empty_count, aclk, aresetn, m_tvalid, m_tdata[43] == (m_tdata[54:44] == 11'd0))

    // Failed extract carries no entry and leaves the heap empty
    `IMPQ_ASSERT_SAME(a_error_clean, aclk, aresetn, m_tvalid && m_tdata[55], m_tdata[42:0] == 43'd0 && m_tdata[43])

    // A found vertex means a non-empty heap
    `IMPQ_ASSERT_SAME(a_found_held, aclk, aresetn, m_tvalid && m_tdata[42], !m_tdata[43] && !m_tdata[55])

endmodule

bind indexed_min_priority_queue iminpq_checker u_iminpq_checker (.*);
